[design/wavetable_oscillator_linear_interp_macros.svh]
// assertion macros for the wavetable oscillator checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef WAVETABLE_OSCILLATOR_LINEAR_INTERP_MACROS_SVH
`define WAVETABLE_OSCILLATOR_LINEAR_INTERP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WTOSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WTOSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wtosc_pkg.sv]
// shared types and constants for the wavetable oscillator
// no dependencies
`timescale 1ns / 1ps

package wtosc_pkg;

    // default sizing
    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int FRAC_BITS_DEFAULT   = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // fixed field widths
    localparam int STEP_W     = 24;
    localparam int SAMPLE_W   = 16;
    localparam int TADDR_W    = 8;
    localparam int IN_DATA_W  = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int CFG_WORD_W = APB_ADDR_W - 2;

    // register word index
    localparam logic [CFG_WORD_W-1:0] REG_PHASE_STEP = '0;

    // item kinds
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // control carried along the interpolation pipeline
    typedef struct packed {
        logic valid;
        logic play;
    } stage_ctrl_t;

endpackage

[design/wavetable_oscillator_linear_interp.sv]
// channel   | ports          | payload
// ----------+----------------+----------------------------------------------
// input     | s_t*           | tuser: op; tdata: table_address, table_value
// result    | m_t*           | tdata: sample; tuser: playing
// config    | apb            | word 0: phase_step
//
// one item per cycle unless stalled; results pass read, product and result registers
// the phase register closes on itself through one add, so ticks follow back to back
// the table is read at two addresses in the transfer cycle of a tick, writes land
// at their own transfer, so a tick right after a write sees the new entry
// a stalled result freezes the whole pipeline; s_tready follows m_tready
// reset clears the phase, the running flag, the step and the pipeline valids
//
// top level of the wavetable oscillator; depends on wtosc_pkg and wtosc_interp
`timescale 1ns / 1ps

module wavetable_oscillator_linear_interp
    import wtosc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] table_address, [23:8] table_value
    input  logic [1:0]            s_tuser,   // [1:0] op
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample
    output logic                  m_tuser,   // [0] playing
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int PHASE_W = ADDR_W + FRAC_BITS;
    localparam int SUM_W   = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;

    logic                   advance;
    logic                   s_accept;
    op_t                    in_op;
    logic [ADDR_W-1:0]      wr_addr;
    logic [SAMPLE_BITS-1:0] wr_value;

    logic [STEP_W-1:0]      phase_step_reg;
    logic                   cfg_write;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic                   running_reg;
    logic                   running_next;
    logic [SUM_W-1:0]       phase_sum;

    logic [ADDR_W-1:0]      idx_i;
    logic [ADDR_W-1:0]      idx_j;

    logic [SAMPLE_BITS-1:0] table_mem [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_a_reg;
    logic [SAMPLE_BITS-1:0] rd_b_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    stage_ctrl_t            s1_ctrl_reg;
    stage_ctrl_t            s1_ctrl_next;

    logic                   out_valid;
    logic                   out_play;
    logic [SAMPLE_BITS-1:0] out_sample;

    // handshake
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;
    assign s_accept = s_tvalid && advance;
    assign in_op    = op_t'(s_tuser);
    assign wr_addr  = ADDR_W'(s_tdata[TADDR_W-1:0]);
    assign wr_value = SAMPLE_BITS'(s_tdata[IN_DATA_W-1:TADDR_W]);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_PHASE_STEP);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_PHASE_STEP)
                       ? APB_DATA_W'(phase_step_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
        end else if (cfg_write) begin
            phase_step_reg <= pwdata[STEP_W-1:0];
        end
    end

    // phase accumulator and run flag
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(phase_step_reg);

    always_comb begin
        phase_next   = phase_reg;
        running_next = running_reg;
        if (s_accept) begin
            case (in_op)
                OP_TICK: begin
                    if (running_reg) begin
                        phase_next = phase_sum[PHASE_W-1:0];
                    end
                end
                OP_WRITE: ;
                OP_START: begin
                    running_next = 1'b1;
                end
                OP_STOP: begin
                    running_next = 1'b0;
                    phase_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            running_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            running_reg <= running_next;
        end
    end

    // table entries around the current phase, wrapping at the end
    assign idx_i = phase_reg[PHASE_W-1:FRAC_BITS];
    assign idx_j = idx_i + ADDR_W'(1);

    // wave table write port
    always_ff @(posedge aclk) begin
        if (s_accept && (in_op == OP_WRITE)) begin
            table_mem[wr_addr] <= wr_value;
        end
    end

    // wave table read ports, held while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_a_reg <= table_mem[idx_i];
            rd_b_reg <= table_mem[idx_j];
            frac_reg <= phase_reg[FRAC_BITS-1:0];
        end
    end

    always_comb begin
        s1_ctrl_next.valid = s_accept && (in_op == OP_TICK);
        s1_ctrl_next.play  = running_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg <= '0;
        end else if (advance) begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    wtosc_interp #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_ctrl    (s1_ctrl_reg),
        .in_a       (rd_a_reg),
        .in_b       (rd_b_reg),
        .in_frac    (frac_reg),
        .out_valid  (out_valid),
        .out_play   (out_play),
        .out_sample (out_sample)
    );

    // result channel
    assign m_tvalid = out_valid;
    assign m_tdata  = SAMPLE_W'(out_sample);
    assign m_tuser  = out_play;

endmodule

[design/wtosc_interp.sv]
// interpolation datapath: difference times fraction, then round and add
// depends on wtosc_pkg
`timescale 1ns / 1ps

module wtosc_interp
    import wtosc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  stage_ctrl_t            in_ctrl,
    input  logic [SAMPLE_BITS-1:0] in_a,
    input  logic [SAMPLE_BITS-1:0] in_b,
    input  logic [FRAC_BITS-1:0]   in_frac,
    output logic                   out_valid,
    output logic                   out_play,
    output logic [SAMPLE_BITS-1:0] out_sample
);

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0]        a_reg;
    stage_ctrl_t                   ctrl_reg;
    logic signed [PROD_W-1:0]      rounded;
    logic [SAMPLE_BITS:0]          sum_w;
    logic                          out_valid_reg;
    logic                          out_play_reg;
    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic [SAMPLE_BITS-1:0]        out_sample_next;

    // slope times fraction
    assign diff      = $signed({in_b[SAMPLE_BITS-1], in_b}) - $signed({in_a[SAMPLE_BITS-1], in_a});
    assign frac_s    = $signed({1'b0, in_frac});
    assign prod_next = PROD_W'(diff) * PROD_W'(frac_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            a_reg    <= in_a;
        end
    end

    // round to nearest, ties up, then add the base entry
    assign rounded = (prod_reg + HALF) >>> FRAC_BITS;
    assign sum_w   = {a_reg[SAMPLE_BITS-1], a_reg} + rounded[SAMPLE_BITS:0];

    always_comb begin
        out_sample_next = ctrl_reg.play ? sum_w[SAMPLE_BITS-1:0] : '0;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= ctrl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_play_reg   <= ctrl_reg.play;
            out_sample_reg <= out_sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_play   = out_play_reg;
    assign out_sample = out_sample_reg;

endmodule

[design/wtosc_checker.sv]
// port-level checks for the wavetable oscillator, bound to the top level
// depends on wtosc_pkg and wavetable_oscillator_linear_interp_macros.svh
`timescale 1ns / 1ps
`include "wavetable_oscillator_linear_interp_macros.svh"

module wtosc_checker
    import wtosc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [SAMPLE_W-1:0]   m_tdata,
    input logic                  m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // a result from a stopped oscillator carries a zero sample
    `WTOSC_ASSERT_NOW(a_stopped_zero, m_tvalid && !m_tuser, m_tdata == '0, "stopped sample not zero")

    // with no result waiting the input side must take a transfer
    `WTOSC_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // a held result keeps its payload
    `WTOSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                       m_tvalid && $stable(m_tdata) && $stable(m_tuser), "held result changed")

    // the step register reads back what was written
    `WTOSC_ASSERT_NEXT(a_step_readback,
                       psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_PHASE_STEP),
                       (paddr[APB_ADDR_W-1:2] != REG_PHASE_STEP)
                       || (prdata == APB_DATA_W'($past(pwdata[STEP_W-1:0]))),
                       "phase step readback mismatch")

endmodule

bind wavetable_oscillator_linear_interp wtosc_checker u_wtosc_checker (.*);
